// File: rtl/abd_pkg.sv
package abd_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned DivNumW  = 42;
  localparam int unsigned DivDenW  = 16;

  typedef enum logic [2:0] {
    CFG_SENS = 3'd0,
    CFG_HPC  = 3'd1,
    CFG_LPC  = 3'd2,
    CFG_REFR = 3'd3,
    CFG_PLEN = 3'd4,
    CFG_WARM = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    FN_PUSH  = 2'd0,
    FN_END   = 2'd1,
    FN_QUERY = 2'd2,
    FN_CLEAR = 2'd3
  } func_e;

  localparam logic [2:0] DEC_BELOW  = 3'd0;
  localparam logic [2:0] DEC_NORISE = 3'd1;
  localparam logic [2:0] DEC_UNARM  = 3'd2;
  localparam logic [2:0] DEC_LOCKED = 3'd3;
  localparam logic [2:0] DEC_HIT    = 3'd4;

  localparam logic REPLY_DECISION = 1'b0;
  localparam logic REPLY_PULSE    = 1'b1;

  typedef struct packed {
    logic [2:0]  sens;
    logic [7:0]  hpc;
    logic [7:0]  lpc;
    logic [15:0] refr;
    logic [15:0] plen;
    logic [7:0]  warm;
  } abd_cfg_t;

  typedef struct packed {
    func_e       func;
    logic [11:0] sample;
    logic [31:0] now;
  } abd_item_t;

  function automatic logic [7:0] floor_of(input logic [2:0] sel);
    logic [7:0] r;
    unique case (sel)
      3'd0:    r = 8'd144;
      3'd1:    r = 8'd100;
      3'd2:    r = 8'd64;
      3'd3:    r = 8'd36;
      default: r = 8'd16;
    endcase
    return r;
  endfunction

  function automatic logic [8:0] ratio_of(input logic [2:0] sel);
    logic [8:0] r;
    unique case (sel)
      3'd0:    r = 9'd300;
      3'd1:    r = 9'd250;
      3'd2:    r = 9'd200;
      3'd3:    r = 9'd150;
      default: r = 9'd100;
    endcase
    return r;
  endfunction

  function automatic logic [23:0] sat24(input logic [31:0] v);
    return (v > 32'h00FF_FFFF) ? 24'hFF_FFFF : v[23:0];
  endfunction

  // One Q8 first-order step: st + (diff * k) / 256, truncated toward zero, clamped.
  function automatic logic signed [31:0] filter_step(input logic signed [31:0] st,
                                                    input logic signed [33:0] diff,
                                                    input logic [7:0] k);
    logic signed [42:0] p;
    logic signed [34:0] t;
    logic signed [35:0] s;
    p = diff * $signed({1'b0, k});
    if (p < 0) t = 35'((p + 43'sd255) >>> 8);
    else       t = 35'(p >>> 8);
    s = 36'(st) + 36'(t);
    if (s > 36'sd2147483647)       return 32'sh7FFF_FFFF;
    else if (s < -36'sd2147483648) return 32'sh8000_0000;
    else                           return s[31:0];
  endfunction

endpackage

// File: rtl/abd_front.sv
module abd_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         func_i,
  input  logic [11:0]        sample_i,
  input  logic [31:0]        now_ms_i,
  output logic               item_valid_o,
  input  logic               item_pop_i,
  output abd_pkg::abd_item_t item_o
);
  import abd_pkg::*;

  abd_item_t  mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push;

  assign in_stall_o   = (cnt_q == 2'd2);
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = mem_q[rd_q];
  assign push         = in_valid_i && !in_stall_o;

  // classify the function code on entry
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= '{func: func_e'(func_i), sample: sample_i, now: now_ms_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (item_pop_i) rd_q <= ~rd_q;
      unique case ({push, item_pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// File: rtl/abd_div.sv
module abd_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [abd_pkg::DivNumW-1:0] num_i,
  input  logic [abd_pkg::DivDenW-1:0] den_i,
  output logic                        done_o,
  output logic [abd_pkg::DivNumW-1:0] quo_o
);
  import abd_pkg::*;

  logic [DivNumW-1:0] quo_q;
  logic [DivDenW-1:0] rem_q, den_q;
  logic [5:0]         step_q;
  logic               busy_q, done_q;
  logic [DivDenW:0]   trial;
  logic               fits;

  assign trial  = {rem_q, quo_q[DivNumW-1]};
  assign fits   = (trial >= {1'b0, den_q});
  assign done_o = done_q;
  assign quo_o  = quo_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= fits ? DivDenW'(trial - {1'b0, den_q}) : trial[DivDenW-1:0];
      quo_q <= {quo_q[DivNumW-2:0], fits};
    end
  end

  // one quotient bit per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= 6'(DivNumW - 1);
      end else if (busy_q) begin
        step_q <= step_q - 6'd1;
        if (step_q == 6'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

// File: rtl/abd_engine.sv
module abd_engine #(
  parameter int unsigned MAX_BLOCK_SAMPLES = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  abd_pkg::abd_cfg_t  cfg_i,
  input  logic               item_valid_i,
  input  abd_pkg::abd_item_t item_i,
  output logic               item_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               reply_kind_o,
  output logic [2:0]         decision_o,
  output logic [23:0]        block_energy_o,
  output logic [23:0]        background_level_o,
  output logic [31:0]        beat_total_o,
  output logic [7:0]         pulse_level_o
);
  import abd_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_BLOCK_SAMPLES + 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_DC, ST_LP1, ST_LP2, ST_ACC,
    ST_END, ST_MEANW, ST_THR,
    ST_PULSE, ST_PULSEW, ST_OUT
  } state_e;

  state_e            state_q;
  abd_item_t         item_q;
  logic signed [31:0] dc_q, lp1_q, lp2_q;
  logic [31:0]       sum_q, smooth_q, prev_q, bg_q, last_q, hits_q;
  logic [CntW-1:0]   cnt_q;
  logic [7:0]        wd_q;
  logic              armed_q, pulse_q, seen_q;
  logic              kind_q;
  logic [2:0]        dec_q;
  logic [7:0]        lvl_q;
  logic              out_valid_q, out_kind_q;
  logic [2:0]        out_dec_q;
  logic [23:0]       out_energy_q, out_bg_q;
  logic [31:0]       out_hits_q;
  logic [7:0]        out_lvl_q;

  // datapath
  logic signed [20:0] x_s;
  logic signed [31:0] f_st, f_out;
  logic signed [33:0] f_diff;
  logic [7:0]         f_k;
  logic signed [32:0] lp2_bias;
  logic signed [24:0] band;
  logic signed [49:0] sq;
  logic [46:0]        acc;
  logic [2:0]         sel;
  logic [7:0]         flr;
  logic               div_start, div_done;
  logic [DivNumW-1:0] div_num, div_quo;
  logic [DivDenW-1:0] div_den;
  logic [31:0]        inst, smooth_n, age, e;
  logic [33:0]        rise_lim;
  logic [40:0]        thr_prod, arm_prod, e_hund, over_hund;
  logic               below, armed_n, locked;
  logic [2:0]         dec_n;
  logic [32:0]        bg_step;
  logic [31:0]        bg_n;
  logic [15:0]        pl_left;

  assign item_pop_o = (state_q == ST_IDLE) && item_valid_i;
  assign x_s        = $signed({1'b0, item_q.sample, 8'h00});
  assign sel        = (cfg_i.sens > 3'd4) ? 3'd4 : cfg_i.sens;
  assign flr        = floor_of(sel);
  assign age        = item_q.now - last_q;
  assign e          = smooth_q;

  always_comb begin
    unique case (state_q)
      ST_DC: begin
        f_st = dc_q; f_k = cfg_i.hpc;
        f_diff = 34'(x_s) - 34'(dc_q);
      end
      ST_LP1: begin
        f_st = lp1_q; f_k = cfg_i.lpc;
        f_diff = 34'(x_s) - 34'(dc_q) - 34'(lp1_q);
      end
      default: begin
        f_st = lp2_q; f_k = cfg_i.lpc;
        f_diff = 34'(lp1_q) - 34'(lp2_q);
      end
    endcase
  end

  assign f_out = filter_step(f_st, f_diff, f_k);

  // band value and its square for the block sum
  assign lp2_bias = 33'(lp2_q) + 33'sd255;
  assign band     = (lp2_q < 0) ? 25'(lp2_bias >>> 8) : 25'(lp2_q >>> 8);
  assign sq       = band * band;
  assign acc      = 47'(sum_q) + {1'b0, sq[49:4]};

  assign inst     = div_quo[31:0];
  assign smooth_n = 32'((33'(smooth_q) + 33'(inst)) >> 1);

  // x <= floor(y / 100) holds exactly when 100 * x <= y, so compare scaled values
  assign thr_prod  = 41'(bg_q) * 41'(ratio_of(sel));
  assign arm_prod  = 41'(bg_q) * 41'd130;
  assign e_hund    = 41'(e) * 41'd100;
  assign over_hund = 41'(e - 32'(flr)) * 41'd100;

  always_comb begin
    below    = (e <= 32'(flr)) || (over_hund <= thr_prod);
    armed_n  = armed_q || (e <= 32'(flr)) || (e_hund <= arm_prod);
    rise_lim = 34'(prev_q) + 34'(flr[7:2]) + 34'd1;
    locked   = seen_q && (age < 32'(cfg_i.refr));
    if (below)                   dec_n = DEC_BELOW;
    else if (34'(e) <= rise_lim) dec_n = DEC_NORISE;
    else if (!armed_n)           dec_n = DEC_UNARM;
    else if (locked)             dec_n = DEC_LOCKED;
    else                         dec_n = DEC_HIT;
    if (e > bg_q) begin
      bg_step = (33'(e) - 33'(bg_q) + 33'd31) >> 5;
      bg_n    = bg_q + bg_step[31:0];
    end else begin
      bg_step = (33'(bg_q) - 33'(e) + 33'd31) >> 5;
      bg_n    = bg_q - bg_step[31:0];
    end
  end

  assign pl_left = cfg_i.plen - age[15:0];

  always_comb begin
    div_start = 1'b0;
    div_num   = DivNumW'(sum_q);
    div_den   = DivDenW'(cnt_q);
    unique case (state_q)
      ST_END:   div_start = (cnt_q != '0);
      ST_PULSE: begin
        div_start = pulse_q && (age < 32'(cfg_i.plen));
        div_num   = DivNumW'(24'(pl_left) * 24'd255);
        div_den   = cfg_i.plen;
      end
      default: div_start = 1'b0;
    endcase
  end

  abd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  always_ff @(posedge clk_i) begin
    if (item_pop_o) item_q <= item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      dc_q         <= '0;
      lp1_q        <= '0;
      lp2_q        <= '0;
      sum_q        <= '0;
      cnt_q        <= '0;
      wd_q         <= '0;
      armed_q      <= 1'b1;
      pulse_q      <= 1'b0;
      seen_q       <= 1'b0;
      smooth_q     <= '0;
      prev_q       <= '0;
      bg_q         <= '0;
      last_q       <= '0;
      hits_q       <= '0;
      kind_q       <= REPLY_DECISION;
      dec_q        <= DEC_BELOW;
      lvl_q        <= '0;
      out_valid_q  <= 1'b0;
      out_kind_q   <= REPLY_DECISION;
      out_dec_q    <= DEC_BELOW;
      out_energy_q <= '0;
      out_bg_q     <= '0;
      out_hits_q   <= '0;
      out_lvl_q    <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && state_q != ST_OUT) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (item_valid_i) begin
            unique case (item_i.func)
              FN_PUSH:  state_q <= ST_DC;
              FN_END:   state_q <= ST_END;
              FN_QUERY: state_q <= ST_PULSE;
              default:  pulse_q <= 1'b0;
            endcase
          end
        end
        ST_DC: begin
          dc_q    <= f_out;
          state_q <= ST_LP1;
        end
        ST_LP1: begin
          lp1_q   <= f_out;
          state_q <= ST_LP2;
        end
        ST_LP2: begin
          lp2_q   <= f_out;
          state_q <= ST_ACC;
        end
        ST_ACC: begin
          // a full block still filters but stops accumulating
          if (cnt_q < CntW'(MAX_BLOCK_SAMPLES)) begin
            sum_q <= (acc > 47'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : acc[31:0];
            cnt_q <= cnt_q + 1'b1;
          end
          state_q <= ST_IDLE;
        end
        ST_END: begin
          state_q <= (cnt_q == '0) ? ST_IDLE : ST_MEANW;
        end
        ST_MEANW: begin
          if (div_done) begin
            sum_q    <= '0;
            cnt_q    <= '0;
            prev_q   <= smooth_q;
            smooth_q <= smooth_n;
            if (wd_q < cfg_i.warm) begin
              bg_q    <= smooth_n;
              wd_q    <= wd_q + 8'd1;
              state_q <= ST_IDLE;
            end else begin
              state_q <= ST_THR;
            end
          end
        end
        ST_THR: begin
          // a hit drops the arming until the energy falls back
          armed_q <= armed_n && (dec_n != DEC_HIT);
          if (dec_n == DEC_HIT) begin
            last_q  <= item_q.now;
            pulse_q <= 1'b1;
            seen_q  <= 1'b1;
            hits_q  <= hits_q + 32'd1;
          end
          bg_q    <= bg_n;
          kind_q  <= REPLY_DECISION;
          dec_q   <= dec_n;
          lvl_q   <= '0;
          state_q <= ST_OUT;
        end
        ST_PULSE: begin
          kind_q <= REPLY_PULSE;
          dec_q  <= DEC_BELOW;
          lvl_q  <= '0;
          if (age >= 32'(cfg_i.plen)) begin
            pulse_q <= 1'b0;
            state_q <= ST_OUT;
          end else if (!pulse_q) begin
            state_q <= ST_OUT;
          end else begin
            state_q <= ST_PULSEW;
          end
        end
        ST_PULSEW: begin
          if (div_done) begin
            lvl_q   <= div_quo[7:0];
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          // hold until the output register is free
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q  <= 1'b1;
            out_kind_q   <= kind_q;
            out_dec_q    <= dec_q;
            out_energy_q <= sat24(smooth_q);
            out_bg_q     <= sat24(bg_q);
            out_hits_q   <= hits_q;
            out_lvl_q    <= lvl_q;
            state_q      <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o        = out_valid_q;
  assign reply_kind_o       = out_kind_q;
  assign decision_o         = out_dec_q;
  assign block_energy_o     = out_energy_q;
  assign background_level_o = out_bg_q;
  assign beat_total_o       = out_hits_q;
  assign pulse_level_o      = out_lvl_q;

endmodule

// File: rtl/audio_beat_detector_unit.sv
// Energy-based audio beat detector.
// Input channel (in_valid_i / in_stall_o): one transfer carries func_i, sample_i and
// now_ms_i. func_i selects push sample, end block, pulse query or clear pulse.
// Output channel (out_valid_o / out_stall_i): one transfer per end block past warm-up
// with a non-empty block (decision reply) and one per pulse query (pulse reply).
// Push sample and clear pulse give no transfer.
// Configuration (cfg_valid_i / cfg_ready_o, cfg_index_i, cfg_data_i): always ready;
// write only while the block is idle.
// Steps: a push sample passes the pop and then the DC, two low-pass and accumulate
// stages, one multiply each. An end block runs one pass of the 42-step restoring
// divider for the block mean; threshold and re-arm tests compare scaled products
// combinationally in the threshold state. A pulse query runs the divider for the
// level when a pulse is active, else replies without it.
// A two-entry queue in front takes new items while the back end works.
// Reset: filters, sums and history clear, the detector is armed, registers return
// to their defaults; nothing is pending on the output.
// A stalled result holds in the output register; the back end then waits before
// its next result while the queue keeps taking items until full.
module audio_beat_detector_unit #(
  parameter int unsigned MAX_BLOCK_SAMPLES = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [abd_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [abd_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    func_i,
  input  logic [11:0]                   sample_i,
  input  logic [31:0]                   now_ms_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          reply_kind_o,
  output logic [2:0]                    decision_o,
  output logic [23:0]                   block_energy_o,
  output logic [23:0]                   background_level_o,
  output logic [31:0]                   beat_total_o,
  output logic [7:0]                    pulse_level_o
);
  import abd_pkg::*;

  abd_cfg_t  cfg_q;
  abd_item_t item;
  logic      item_valid, item_pop;

  assign cfg_ready_o = 1'b1;

  // register file: indexes past the last register are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{sens: 3'd2, hpc: 8'd2, lpc: 8'd64, refr: 16'd150,
                 plen: 16'd100, warm: 8'd8};
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_SENS: cfg_q.sens <= cfg_data_i[2:0];
        CFG_HPC:  cfg_q.hpc  <= cfg_data_i[7:0];
        CFG_LPC:  cfg_q.lpc  <= cfg_data_i[7:0];
        CFG_REFR: cfg_q.refr <= cfg_data_i;
        CFG_PLEN: cfg_q.plen <= cfg_data_i;
        CFG_WARM: cfg_q.warm <= cfg_data_i[7:0];
        default:  cfg_q      <= cfg_q;
      endcase
    end
  end

  // front: accept and classify, queue two items
  abd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .sample_i    (sample_i),
    .now_ms_i    (now_ms_i),
    .item_valid_o(item_valid),
    .item_pop_i  (item_pop),
    .item_o      (item)
  );

  // back: filters, block statistics, decisions and pulse level
  abd_engine #(
    .MAX_BLOCK_SAMPLES(MAX_BLOCK_SAMPLES)
  ) u_engine (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg_q),
    .item_valid_i      (item_valid),
    .item_i            (item),
    .item_pop_o        (item_pop),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .reply_kind_o      (reply_kind_o),
    .decision_o        (decision_o),
    .block_energy_o    (block_energy_o),
    .background_level_o(background_level_o),
    .beat_total_o      (beat_total_o),
    .pulse_level_o     (pulse_level_o)
  );

endmodule

// File: rtl/abd_checker.sv
module abd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        reply_kind_o,
  input logic [2:0]  decision_o,
  input logic [31:0] beat_total_o,
  input logic [7:0]  pulse_level_o
);
  import abd_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(decision_o)
      && $stable(beat_total_o) && $stable(pulse_level_o))
    else $error("stalled result changed");

  a_dec_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> decision_o <= DEC_HIT)
    else $error("decision code out of range");

  a_pulse_nodec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && reply_kind_o == REPLY_PULSE |-> decision_o == DEC_BELOW)
    else $error("pulse reply carries a decision");

  a_dec_nolvl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && reply_kind_o == REPLY_DECISION |-> pulse_level_o == 8'd0)
    else $error("decision reply carries a pulse level");

endmodule

bind audio_beat_detector_unit abd_checker u_abd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .reply_kind_o (reply_kind_o),
  .decision_o   (decision_o),
  .beat_total_o (beat_total_o),
  .pulse_level_o(pulse_level_o)
);
